### rtl/gopd_pkg.sv
package gopd_pkg;

    localparam int MAX_POINTS = 64;

    // widths fixed by the stream format
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int COORD_W = 16;
    localparam int BYTE_W  = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    // flag byte bits
    localparam int BIT_ON_CURVE = 0;
    localparam int BIT_X_SHORT  = 1;
    localparam int BIT_Y_SHORT  = 2;
    localparam int BIT_REPEAT   = 3;
    localparam int BIT_X_SAME   = 4;
    localparam int BIT_Y_SAME   = 5;

    // input kinds on s_tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FLAGS = 2'd1,
        PH_X     = 2'd2,
        PH_Y     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_FLAG_END,
        ST_COPY,
        ST_ERR,
        ST_FETCH,
        ST_CHECK,
        ST_COMMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_FLAG_WRITE,
        OP_COPY_LOAD,
        OP_COPY_STEP,
        OP_ERROR,
        OP_TO_X,
        OP_TO_Y,
        OP_TO_IDLE,
        OP_FETCH,
        OP_HOLD_HIGH,
        OP_DELTA_SHORT,
        OP_DELTA_LONG,
        OP_DELTA_ZERO,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   pending;
        logic   at_end;
        logic   overrun;
        logic   byte_zero;
        logic   copy_last;
        logic   is_short;
        logic   is_pos;
        logic   held;
        logic   out_free;
    } status_t;

endpackage

### rtl/gopd_ctrl.sv
module gopd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    input  gopd_pkg::status_t st,
    output gopd_pkg::cmd_t    cmd
);

    gopd_pkg::state_t state_reg;
    gopd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gopd_pkg::ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = gopd_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            gopd_pkg::ST_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == gopd_pkg::KIND_START)
                    begin
                        cmd.op = gopd_pkg::OP_START;
                    end
                    else
                    begin
                        case (st.phase)
                            gopd_pkg::PH_FLAGS:
                            begin
                                if (st.pending)
                                begin
                                    if (st.overrun)
                                    begin
                                        state_next = gopd_pkg::ST_ERR;
                                    end
                                    else
                                    begin
                                        cmd.op     = gopd_pkg::OP_COPY_LOAD;
                                        state_next = st.byte_zero ? gopd_pkg::ST_FLAG_END
                                                                  : gopd_pkg::ST_COPY;
                                    end
                                end
                                else
                                begin
                                    cmd.op     = gopd_pkg::OP_FLAG_WRITE;
                                    state_next = gopd_pkg::ST_FLAG_END;
                                end
                            end
                            gopd_pkg::PH_X, gopd_pkg::PH_Y:
                            begin
                                if (st.is_short)
                                begin
                                    cmd.op     = gopd_pkg::OP_DELTA_SHORT;
                                    state_next = gopd_pkg::ST_COMMIT;
                                end
                                else if (!st.held)
                                begin
                                    cmd.op = gopd_pkg::OP_HOLD_HIGH;
                                end
                                else
                                begin
                                    cmd.op     = gopd_pkg::OP_DELTA_LONG;
                                    state_next = gopd_pkg::ST_COMMIT;
                                end
                            end
                            default:
                            begin
                                cmd.op = gopd_pkg::OP_NONE;
                            end
                        endcase
                    end
                end
            end
            gopd_pkg::ST_FLAG_END:
            begin
                if (st.at_end && !st.pending)
                begin
                    cmd.op     = gopd_pkg::OP_TO_X;
                    state_next = gopd_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = gopd_pkg::ST_WAIT;
                end
            end
            gopd_pkg::ST_COPY:
            begin
                cmd.op = gopd_pkg::OP_COPY_STEP;
                if (st.copy_last)
                begin
                    state_next = gopd_pkg::ST_FLAG_END;
                end
            end
            gopd_pkg::ST_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.op     = gopd_pkg::OP_ERROR;
                    state_next = gopd_pkg::ST_WAIT;
                end
            end
            gopd_pkg::ST_FETCH:
            begin
                if (st.at_end && st.phase == gopd_pkg::PH_X)
                begin
                    cmd.op = gopd_pkg::OP_TO_Y;
                end
                else if (st.at_end)
                begin
                    cmd.op     = gopd_pkg::OP_TO_IDLE;
                    state_next = gopd_pkg::ST_WAIT;
                end
                else
                begin
                    cmd.op     = gopd_pkg::OP_FETCH;
                    state_next = gopd_pkg::ST_CHECK;
                end
            end
            gopd_pkg::ST_CHECK:
            begin
                // point needs no byte when not short and the same bit is set
                if (!st.is_short && st.is_pos)
                begin
                    cmd.op     = gopd_pkg::OP_DELTA_ZERO;
                    state_next = gopd_pkg::ST_COMMIT;
                end
                else
                begin
                    state_next = gopd_pkg::ST_WAIT;
                end
            end
            gopd_pkg::ST_COMMIT:
            begin
                if (st.phase != gopd_pkg::PH_Y || st.out_free)
                begin
                    cmd.op     = gopd_pkg::OP_COMMIT;
                    state_next = gopd_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = gopd_pkg::ST_WAIT;
            end
        endcase
    end

endmodule

### rtl/gopd_dpath.sv
module gopd_dpath #(
    parameter int MAX_POINTS = gopd_pkg::MAX_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gopd_pkg::cmd_t                cmd,
    output gopd_pkg::status_t             st,
    input  logic [gopd_pkg::CNT_W-1:0]    in_count,
    input  logic [gopd_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gopd_pkg::M_DATA_W-1:0] out_data,
    output logic                          out_last,
    output logic                          out_error
);

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [gopd_pkg::CNT_W-1:0] MAX_CNT = gopd_pkg::CNT_W'(MAX_POINTS);

    logic [gopd_pkg::BYTE_W-1:0]  flag_mem [MAX_POINTS];
    logic [gopd_pkg::COORD_W-1:0] x_mem    [MAX_POINTS];

    gopd_pkg::phase_t             phase_reg;
    logic [gopd_pkg::CNT_W-1:0]   cursor_reg;
    logic [gopd_pkg::CNT_W-1:0]   total_reg;
    logic                         pending_reg;
    logic [gopd_pkg::BYTE_W:0]    held_reg;
    logic [gopd_pkg::COORD_W-1:0] running_reg;
    logic [gopd_pkg::COORD_W-1:0] delta_reg;
    logic [gopd_pkg::CNT_W-1:0]   copy_cnt_reg;
    logic [gopd_pkg::BYTE_W-1:0]  last_flag_reg;
    logic [gopd_pkg::BYTE_W-1:0]  flag_rd_reg;
    logic [gopd_pkg::COORD_W-1:0] x_rd_reg;
    logic                         out_valid_reg;
    logic [gopd_pkg::M_DATA_W-1:0] out_data_reg;
    logic                         out_last_reg;
    logic                         out_error_reg;

    logic [ADDR_W-1:0]            addr;
    logic [gopd_pkg::CNT_W-1:0]   cursor_inc;
    logic [gopd_pkg::CNT_W-1:0]   cursor_dec;
    logic [gopd_pkg::COORD_W-1:0] coord_sum;
    logic                         out_load;
    logic                         flag_we;
    logic [gopd_pkg::BYTE_W-1:0]  flag_wdata;
    logic [gopd_pkg::BYTE_W:0]    run_end;
    logic [gopd_pkg::COORD_W-1:0] byte_ext;

    assign addr       = cursor_reg[ADDR_W-1:0];
    assign cursor_inc = cursor_reg + 1'b1;
    assign cursor_dec = cursor_reg - 1'b1;
    assign coord_sum  = running_reg + delta_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_load   = (cmd.op == gopd_pkg::OP_ERROR) ||
                        (cmd.op == gopd_pkg::OP_COMMIT && phase_reg == gopd_pkg::PH_Y);
    assign flag_we    = (cmd.op == gopd_pkg::OP_FLAG_WRITE) ||
                        (cmd.op == gopd_pkg::OP_COPY_STEP);
    assign flag_wdata = (cmd.op == gopd_pkg::OP_FLAG_WRITE) ? in_byte : last_flag_reg;
    assign run_end    = {2'b00, cursor_reg} + {1'b0, in_byte};
    assign byte_ext   = {{(gopd_pkg::COORD_W-gopd_pkg::BYTE_W){1'b0}}, in_byte};

    logic out_free;

    always_comb
    begin
        st.phase     = phase_reg;
        st.pending   = pending_reg;
        st.at_end    = (cursor_reg >= total_reg);
        st.overrun   = (run_end > {2'b00, total_reg});
        st.byte_zero = (in_byte == '0);
        st.copy_last = (copy_cnt_reg == gopd_pkg::CNT_W'(1));
        st.is_short  = (phase_reg == gopd_pkg::PH_X) ? flag_rd_reg[gopd_pkg::BIT_X_SHORT]
                                                     : flag_rd_reg[gopd_pkg::BIT_Y_SHORT];
        st.is_pos    = (phase_reg == gopd_pkg::PH_X) ? flag_rd_reg[gopd_pkg::BIT_X_SAME]
                                                     : flag_rd_reg[gopd_pkg::BIT_Y_SAME];
        st.held      = held_reg[gopd_pkg::BYTE_W];
        st.out_free  = out_free;
    end

    // point stores
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[addr] <= flag_wdata;
        end
        if (cmd.op == gopd_pkg::OP_COMMIT && phase_reg == gopd_pkg::PH_X)
        begin
            x_mem[addr] <= coord_sum;
        end
        if (cmd.op == gopd_pkg::OP_FETCH)
        begin
            flag_rd_reg <= flag_mem[addr];
            x_rd_reg    <= x_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= gopd_pkg::PH_IDLE;
            cursor_reg  <= '0;
            total_reg   <= '0;
            pending_reg <= 1'b0;
            held_reg    <= '0;
            running_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                gopd_pkg::OP_START:
                begin
                    cursor_reg  <= '0;
                    pending_reg <= 1'b0;
                    held_reg    <= '0;
                    running_reg <= '0;
                    total_reg   <= (in_count > MAX_CNT) ? MAX_CNT : in_count;
                    phase_reg   <= (in_count == '0) ? gopd_pkg::PH_IDLE : gopd_pkg::PH_FLAGS;
                end
                gopd_pkg::OP_FLAG_WRITE:
                begin
                    cursor_reg  <= cursor_inc;
                    pending_reg <= in_byte[gopd_pkg::BIT_REPEAT];
                end
                gopd_pkg::OP_COPY_LOAD:
                begin
                    pending_reg <= 1'b0;
                end
                gopd_pkg::OP_COPY_STEP:
                begin
                    cursor_reg <= cursor_inc;
                end
                gopd_pkg::OP_ERROR:
                begin
                    pending_reg <= 1'b0;
                    phase_reg   <= gopd_pkg::PH_IDLE;
                end
                gopd_pkg::OP_TO_X:
                begin
                    phase_reg   <= gopd_pkg::PH_X;
                    cursor_reg  <= '0;
                    running_reg <= '0;
                    held_reg    <= '0;
                end
                gopd_pkg::OP_TO_Y:
                begin
                    phase_reg   <= gopd_pkg::PH_Y;
                    cursor_reg  <= '0;
                    running_reg <= '0;
                    held_reg    <= '0;
                end
                gopd_pkg::OP_TO_IDLE:
                begin
                    phase_reg <= gopd_pkg::PH_IDLE;
                end
                gopd_pkg::OP_HOLD_HIGH:
                begin
                    held_reg <= {1'b1, in_byte};
                end
                gopd_pkg::OP_DELTA_LONG:
                begin
                    held_reg <= '0;
                end
                gopd_pkg::OP_COMMIT:
                begin
                    running_reg <= coord_sum;
                    cursor_reg  <= cursor_inc;
                end
                default:
                begin
                    cursor_reg <= cursor_reg;
                end
            endcase
        end
    end

    // delta, copy run and last written flag
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            gopd_pkg::OP_DELTA_SHORT:
            begin
                delta_reg <= st.is_pos ? byte_ext : (gopd_pkg::COORD_W'(0) - byte_ext);
            end
            gopd_pkg::OP_DELTA_LONG:
            begin
                delta_reg <= {held_reg[gopd_pkg::BYTE_W-1:0], in_byte};
            end
            gopd_pkg::OP_DELTA_ZERO:
            begin
                delta_reg <= '0;
            end
            gopd_pkg::OP_COPY_LOAD:
            begin
                copy_cnt_reg <= in_byte[gopd_pkg::CNT_W-1:0];
            end
            gopd_pkg::OP_COPY_STEP:
            begin
                copy_cnt_reg <= copy_cnt_reg - 1'b1;
            end
            gopd_pkg::OP_FLAG_WRITE:
            begin
                last_flag_reg <= in_byte;
            end
            default:
            begin
                delta_reg <= delta_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == gopd_pkg::OP_ERROR)
        begin
            out_data_reg  <= {{(gopd_pkg::M_DATA_W-gopd_pkg::IDX_W){1'b0}},
                              cursor_dec[gopd_pkg::IDX_W-1:0]};
            out_last_reg  <= 1'b1;
            out_error_reg <= 1'b1;
        end
        else if (out_load)
        begin
            out_data_reg  <= {1'b0, flag_rd_reg[gopd_pkg::BIT_ON_CURVE], coord_sum, x_rd_reg,
                              cursor_reg[gopd_pkg::IDX_W-1:0]};
            out_last_reg  <= (cursor_inc >= total_reg);
            out_error_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_error = out_error_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cursor_reg <= total_reg)
        else $error("cursor past point count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_error_reg |-> out_last_reg)
        else $error("error result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg[gopd_pkg::BYTE_W] |-> (phase_reg == gopd_pkg::PH_X ||
                                         phase_reg == gopd_pkg::PH_Y))
        else $error("high byte held outside a coordinate pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> phase_reg == gopd_pkg::PH_FLAGS)
        else $error("repeat pending outside flag pass");

endmodule

### rtl/glyph_outline_point_decoder_unit.sv
// Simple glyph point decoder.
// Input stream (s_*): one transaction per item. s_tuser = 0 starts a glyph with
// the point count in s_tdata[6:0]; s_tuser = 1 carries one byte in s_tdata[14:7]
// (flags, then x deltas, then y deltas). A start may arrive at any time and drops
// the glyph in flight.
// Output stream (m_*): one transaction per point during the y pass, tlast on the
// final point; an overrunning flag repeat gives a single transaction with
// tuser = 1 and tlast = 1, and the glyph is abandoned.
// Flag bytes settle through a flag-end check, a repeat count is copied one flag
// per cycle, a coordinate byte that completes a delta passes through commit,
// fetch and check, and each point whose delta needs no byte goes through the
// flag store read, check and commit steps of the single-port point stores.
// One result register sits on the output: the next item is accepted while a
// result waits, and the decoder only stalls when it must emit a second one.
// Reset clears the controller and returns the decoder to idle; the point stores
// are not cleared and are only used after being written by the current glyph.
module glyph_outline_point_decoder_unit #(
    parameter int MAX_POINTS = gopd_pkg::MAX_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gopd_pkg::S_DATA_W-1:0] s_tdata,  // point_count[6:0], data_byte[14:7]
    input  logic                          s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gopd_pkg::M_DATA_W-1:0] m_tdata,  // point_index[5:0], x_coord[21:6],
                                                    // y_coord[37:22], on_curve[38]
    output logic                          m_tlast,
    output logic                          m_tuser   // error
);

    gopd_pkg::cmd_t    cmd;
    gopd_pkg::status_t st;
    logic              take;

    assign take = s_tvalid && s_tready;

    gopd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    gopd_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_count  (s_tdata[gopd_pkg::CNT_W-1:0]),
        .in_byte   (s_tdata[gopd_pkg::CNT_W+gopd_pkg::BYTE_W-1:gopd_pkg::CNT_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_error (m_tuser)
    );

    // start, flag write and hold-high commands only ever issue on a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gopd_pkg::OP_START || cmd.op == gopd_pkg::OP_FLAG_WRITE ||
         cmd.op == gopd_pkg::OP_HOLD_HIGH) |-> take)
        else $error("input command without transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && s_tuser == gopd_pkg::KIND_START |=> !st.pending && !st.held)
        else $error("start did not clear decode state");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule
